// ===== src/ucv_pkg.sv =====
// shared types, constants and code point checks for the utf-8 charset validator
`default_nettype none

package ucv_pkg;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam int CpW = 21;

	localparam logic [CpW-1:0] CpMax      = 21'h10ffff;
	localparam logic [CpW-1:0] SurrLow    = 21'h00d800;
	localparam logic [CpW-1:0] SurrHigh   = 21'h00dfff;
	localparam logic [CpW-1:0] Min2Byte   = 21'h000080;
	localparam logic [CpW-1:0] Min3Byte   = 21'h000800;
	localparam logic [CpW-1:0] Min4Byte   = 21'h010000;

	localparam logic [7:0] Lead2Mask  = 8'he0;
	localparam logic [7:0] Lead2Match = 8'hc0;
	localparam logic [7:0] Lead3Mask  = 8'hf0;
	localparam logic [7:0] Lead3Match = 8'he0;
	localparam logic [7:0] Lead4Mask  = 8'hf8;
	localparam logic [7:0] Lead4Match = 8'hf0;
	localparam logic [7:0] ContMask   = 8'hc0;
	localparam logic [7:0] ContMatch  = 8'h80;

	// sequence length minus one
	localparam logic [1:0] LenOne   = 2'd0;
	localparam logic [1:0] LenTwo   = 2'd1;
	localparam logic [1:0] LenThree = 2'd2;
	localparam logic [1:0] LenFour  = 2'd3;

	typedef enum logic [2:0] {
		KIND_ASCII,
		KIND_LEAD2,
		KIND_LEAD3,
		KIND_LEAD4,
		KIND_CONT,
		KIND_BAD
	} ucv_kind_t;

	// one classified byte as it travels through the queue
	typedef struct packed {
		ucv_kind_t  kind;
		logic [6:0] bits;      // payload bits, lead marker already stripped
		logic       ascii_ok;  // single byte code point is in the allowed set
		logic       last;
	} ucv_item_t;

	function automatic logic cp_allowed(input logic [CpW-1:0] cp);
		return cp inside {[21'h000020:21'h00007e], 21'h00000a, 21'h00000d, 21'h000009,
			[21'h000410:21'h00044f], 21'h000401, 21'h000451,
			[21'h002010:21'h002015],
			21'h0000a0, 21'h0000ab, 21'h0000bb,
			21'h002018, 21'h002019, 21'h00201c, 21'h00201d,
			21'h002026, 21'h00202f, 21'h0020bd, 21'h002116};
	endfunction

	// range, overlong, surrogate and allowed-set checks on a finished code point
	function automatic logic cp_legal(input logic [CpW-1:0] cp, input logic [1:0] len);
		logic [CpW-1:0] minimum;
		case (len)
			LenTwo:   minimum = Min2Byte;
			LenThree: minimum = Min3Byte;
			LenFour:  minimum = Min4Byte;
			default:  minimum = '0;
		endcase
		return (cp >= minimum) && (cp <= CpMax) &&
			!((cp >= SurrLow) && (cp <= SurrHigh)) && cp_allowed(cp);
	endfunction

endpackage

`default_nettype wire

// ===== src/utf8_charset_validator_unit.sv =====
// top level of the utf-8 charset validator: front, queue and back end
`default_nettype none

//  channel | signals                        | direction | meaning
//  in      | in_valid in_ready              | into unit | one text byte per item
//          | data_byte[7:0] last_byte       |           | last_byte marks string end
//  out     | out_valid out_ready string_ok  | out of    | one verdict per string
//
//  one byte per cycle sustained unless a stalled verdict fills the queue; the decoder
//  state update is the single-cycle loop. out_valid rises once the final byte has
//  passed the queue entry register and then the back end's out_valid register
//  reset clears the queue, decoder state and verdict slot; no clearing pass
//  a stalled verdict only holds up the next final byte; other bytes keep
//  draining, and the four-entry queue absorbs short stalls on either side

module utf8_charset_validator_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic       string_ok
);
	import ucv_pkg::*;

	ucv_item_t front_item;   // classified byte from the front end
	ucv_item_t head_item;    // oldest queued item
	logic      head_valid;
	logic      head_ready;

	// front end: pure classification of the incoming byte
	ucv_front u_front (
		.data_byte (data_byte),
		.last_byte (last_byte),
		.item      (front_item)
	);

	// decoupling queue, which absorbs short stalls between input and output
	ucv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_item  (front_item),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_item   (head_item)
	);

	// back end: sequence decode, sticky failure, registered verdict
	ucv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (head_valid),
		.item_ready (head_ready),
		.item       (head_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.string_ok  (string_ok)
	);

`ifndef NO_ASSERTIONS
	// a final byte taken by the back end always raises a verdict next cycle
	a_last_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && head_ready && head_item.last |=> out_valid)
		else $error("final item did not produce a verdict");

	// a verdict never shows up without a final byte having been taken
	a_verdict_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(head_valid && head_ready && head_item.last))
		else $error("verdict raised without a final item");

	// non-final bytes are never held back by the back end
	a_nonlast_flows: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !head_item.last |-> head_ready)
		else $error("back end stalled a non-final item");
`endif

endmodule

`default_nettype wire

// ===== src/ucv_front.sv =====
// front end: sorts each incoming byte into ascii, lead, continuation or bad
`default_nettype none

module ucv_front (
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	output      ucv_pkg::ucv_item_t item
);
	import ucv_pkg::*;

	always_comb begin
		item.last     = last_byte;
		item.ascii_ok = cp_allowed({14'd0, data_byte[6:0]});
		item.bits     = data_byte[6:0];
		item.kind     = KIND_BAD;
		if (!data_byte[7]) begin
			item.kind = KIND_ASCII;
		end else if ((data_byte & ContMask) == ContMatch) begin
			item.kind = KIND_CONT;
			item.bits = {1'b0, data_byte[5:0]};
		end else if ((data_byte & Lead2Mask) == Lead2Match) begin
			item.kind = KIND_LEAD2;
			item.bits = {2'b0, data_byte[4:0]};
		end else if ((data_byte & Lead3Mask) == Lead3Match) begin
			item.kind = KIND_LEAD3;
			item.bits = {3'b0, data_byte[3:0]};
		end else if ((data_byte & Lead4Mask) == Lead4Match) begin
			item.kind = KIND_LEAD4;
			item.bits = {4'b0, data_byte[2:0]};
		end
	end

endmodule

`default_nettype wire

// ===== src/ucv_queue.sv =====
// short fifo of classified items between the front and back ends
`default_nettype none

module ucv_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output      logic               push_ready,
	input  wire ucv_pkg::ucv_item_t push_item,
	output      logic               pop_valid,
	input  wire logic               pop_ready,
	output      ucv_pkg::ucv_item_t pop_item
);
	import ucv_pkg::*;

	ucv_item_t             entry_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueueCntW-1:0]  count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != QueueCntW'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QueueCntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QueueCntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/ucv_back.sv =====
// back end: utf-8 sequence decoder, sticky failure and verdict register
`default_nettype none

module ucv_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output      logic               item_ready,
	input  wire ucv_pkg::ucv_item_t item,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic               string_ok
);
	import ucv_pkg::*;

	logic [CpW-1:0] cp_q, cp_n;
	logic [1:0]     rem_q, rem_n;
	logic [1:0]     len_q, len_n;
	logic           failed_q, failed_n;
	logic           out_valid_q;
	logic           string_ok_q;
	logic           verdict;
	logic           fail;
	logic [CpW-1:0] shifted;
	logic           take;

	// a non-final item never waits; a final one needs the verdict slot free
	assign item_ready = !item.last || !out_valid_q || out_ready;
	assign take       = item_valid && item_ready;
	assign out_valid  = out_valid_q;
	assign string_ok  = string_ok_q;

	always_comb begin
		cp_n     = cp_q;
		rem_n    = rem_q;
		len_n    = len_q;
		failed_n = failed_q;
		fail     = 1'b0;
		shifted  = {cp_q[CpW-7:0], item.bits[5:0]};
		if (!failed_q) begin
			if (rem_q == 2'd0) begin
				case (item.kind)
					KIND_ASCII: begin
						fail = !item.ascii_ok;
					end
					KIND_LEAD2: begin
						cp_n  = CpW'(item.bits);
						rem_n = 2'd1;
						len_n = LenTwo;
					end
					KIND_LEAD3: begin
						cp_n  = CpW'(item.bits);
						rem_n = 2'd2;
						len_n = LenThree;
					end
					KIND_LEAD4: begin
						cp_n  = CpW'(item.bits);
						rem_n = 2'd3;
						len_n = LenFour;
					end
					default: begin
						fail = 1'b1;
					end
				endcase
			end else if (item.kind != KIND_CONT) begin
				fail = 1'b1;
			end else begin
				rem_n = rem_q - 2'd1;
				if (rem_q == 2'd1) begin
					cp_n  = '0;
					len_n = LenOne;
					fail  = !cp_legal(shifted, len_q);
				end else begin
					cp_n = shifted;
				end
			end
		end
		if (fail) begin
			failed_n = 1'b1;
			cp_n     = '0;
			rem_n    = '0;
			len_n    = LenOne;
		end
		// a sequence cut off by the end of the string fails too
		verdict = !failed_n && (rem_n == 2'd0);
		if (item.last) begin
			failed_n = 1'b0;
			cp_n     = '0;
			rem_n    = '0;
			len_n    = LenOne;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q        <= '0;
			rem_q       <= '0;
			len_q       <= LenOne;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cp_q     <= cp_n;
				rem_q    <= rem_n;
				len_q    <= len_n;
				failed_q <= failed_n;
			end
			if (take && item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.last) begin
			string_ok_q <= verdict;
		end
	end

endmodule

`default_nettype wire
